/* rtl/core/kpdc_pkg.sv */
// Shared types and constants of the keyed packet decrypt and check block.
// No dependencies; every other file of the block but kpdc_ram imports this package.
`default_nettype none

package kpdc_pkg;

    localparam int TABLE_DEPTH = 512;

    localparam int BYTE_W    = 8;
    localparam int SIZE_W    = 16;
    localparam int TADDR_W   = 9;
    localparam int STATUS_W  = 2;

    localparam logic [SIZE_W-1:0] MIN_SIZE       = 16'd12;
    localparam logic [SIZE_W-1:0] MAX_SIZE_RESET = 16'd8192;

    // Item kinds on the input channel
    localparam logic MODE_TABLE  = 1'b0;
    localparam logic MODE_STREAM = 1'b1;

    // Byte positions of the packet header
    localparam logic [SIZE_W-1:0] POS_SIZE_LO = 16'd0;
    localparam logic [SIZE_W-1:0] POS_SIZE_HI = 16'd1;
    localparam logic [SIZE_W-1:0] POS_KEY_IDX = 16'd2;
    localparam logic [SIZE_W-1:0] POS_CHECK   = 16'd3;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_CHECKSUM = 2'd1,
        ST_BAD_SIZE = 2'd2
    } t_status;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              last;
        t_status           status;
        logic [SIZE_W-1:0] packet_size;
    } t_result;

endpackage

`default_nettype wire

/* rtl/core/kpdc_in_if.sv */
// Input channel: table writes and stream bytes, valid/ready handshake.
// Depends on kpdc_pkg.
`default_nettype none

interface kpdc_in_if import kpdc_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               mode;
    logic [TADDR_W-1:0] table_addr;
    logic [BYTE_W-1:0]  table_data;
    logic [BYTE_W-1:0]  stream_byte;

    modport source (output valid, output mode, output table_addr, output table_data,
                    output stream_byte, input ready);
    modport sink   (input valid, input mode, input table_addr, input table_data,
                    input stream_byte, output ready);
endinterface

`default_nettype wire

/* rtl/core/kpdc_out_if.sv */
// Result channel: decoded bytes with framing status, valid/ready handshake.
// Depends on kpdc_pkg.
`default_nettype none

interface kpdc_out_if import kpdc_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [BYTE_W-1:0]   out_byte;
    logic                last;
    logic [STATUS_W-1:0] status;
    logic [SIZE_W-1:0]   packet_size;

    modport source (output valid, output out_byte, output last, output status,
                    output packet_size, input ready);
    modport sink   (input valid, input out_byte, input last, input status,
                    input packet_size, output ready);
endinterface

`default_nettype wire

/* rtl/core/kpdc_cfg_if.sv */
// Configuration write channel for the maximum packet size register.
// Depends on kpdc_pkg.
`default_nettype none

interface kpdc_cfg_if import kpdc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [SIZE_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* rtl/core/keyed_packet_decrypt_check.sv */
// Top level of the keyed packet decrypt and check block: input register,
// key table RAM, framing stage and result register.
// Depends on kpdc_pkg, kpdc_in_if, kpdc_out_if, kpdc_cfg_if, kpdc_ram, kpdc_frame.
//
//   channel  dir  payload                                        note
//   i_in     in   mode, table_addr, table_data, stream_byte      table write or byte
//   o_out    out  out_byte, last, status, packet_size            one per stream byte
//   i_cfg    in   data (max_packet_size)                         always ready
//
// One item per cycle sustained while o_out is ready. A stream byte's result passes
// through the input register, then the result register, before it is valid on
// o_out. The key table read is issued at accept from the state the previous
// byte leaves, so its data meets the byte in the input register. Table writes go to
// the RAM at accept and give no result.
// Sync reset clears framing state and valids, reloads max size; table needs none.
// A stalled result holds both registers; input ready drops only when both are full.
`default_nettype none

module keyed_packet_decrypt_check import kpdc_pkg::*; #(
    parameter int TABLE_DEPTH = kpdc_pkg::TABLE_DEPTH
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    kpdc_in_if.sink      i_in,
    kpdc_out_if.source   o_out,
    kpdc_cfg_if.sink     i_cfg
);

    localparam int AW = $clog2(TABLE_DEPTH);

    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_out_valid;
    t_result           r_out;
    logic [SIZE_W-1:0] r_max_size;

    logic              advance;
    logic              accept;
    logic              accept_stream;
    logic              accept_table;
    logic              step;
    logic [BYTE_W-1:0] key;
    logic [AW-1:0]     rd_addr;
    t_result           res;

    assign advance       = !r_out_valid || o_out.ready;
    assign i_in.ready    = !r_in_valid || advance;
    assign accept        = i_in.valid && i_in.ready;
    assign accept_stream = accept && (i_in.mode == MODE_STREAM);
    assign accept_table  = accept && (i_in.mode == MODE_TABLE);
    assign step          = r_in_valid && advance;

    assign i_cfg.ready = 1'b1;

    kpdc_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (TABLE_DEPTH)
    ) u_key_table (
        .i_clk   (i_clk),
        .i_we    (accept_table),
        .i_waddr (AW'(i_in.table_addr)),
        .i_wdata (i_in.table_data),
        .i_re    (accept_stream),
        .i_raddr (rd_addr),
        .o_rdata (key)
    );

    kpdc_frame #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_frame (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_byte      (r_in_byte),
        .i_key       (key),
        .i_max_size  (r_max_size),
        .i_next_byte (i_in.stream_byte),
        .o_rd_addr   (rd_addr),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_max_size  <= MAX_SIZE_RESET;
        end else begin
            if (accept_stream) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
            if (i_cfg.valid && i_cfg.ready) begin
                r_max_size <= i_cfg.data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept_stream) begin
            r_in_byte <= i_in.stream_byte;
        end
        if (step) begin
            r_out <= res;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.out_byte    = r_out.out_byte;
    assign o_out.last        = r_out.last;
    assign o_out.status      = r_out.status;
    assign o_out.packet_size = r_out.packet_size;

`ifndef NO_ASSERTIONS
    // Any error status closes the packet
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status != ST_OK) |-> r_out.last)
        else $error("error result without last");

    // Only a failing result carries a packet size
    a_size_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status == ST_OK) |-> (r_out.packet_size == '0))
        else $error("packet size on an ok result");

    // A byte held in the input register during a stall is not dropped
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> (r_in_valid && $stable(r_in_byte)))
        else $error("stalled item lost");
`endif

endmodule

`default_nettype wire

/* rtl/core/kpdc_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No package dependency.
`default_nettype none

module kpdc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* rtl/core/kpdc_frame.sv */
// Packet framing, decryption and checksum state for one stream byte per step.
// Also forms the key table read address for the byte that follows.
// Depends on kpdc_pkg.
`default_nettype none

module kpdc_frame import kpdc_pkg::*; #(
    parameter int TABLE_DEPTH = kpdc_pkg::TABLE_DEPTH
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_step,
    input  wire logic [BYTE_W-1:0]              i_byte,
    input  wire logic [BYTE_W-1:0]              i_key,
    input  wire logic [SIZE_W-1:0]              i_max_size,
    input  wire logic [BYTE_W-1:0]              i_next_byte,
    output logic      [$clog2(TABLE_DEPTH)-1:0] o_rd_addr,
    output t_result                             o_res
);

    localparam int AW = $clog2(TABLE_DEPTH);

    logic [SIZE_W-1:0] r_count, n_count;
    logic [SIZE_W-1:0] r_size,  n_size;
    logic [BYTE_W-1:0] r_key_pos, n_key_pos;
    logic [BYTE_W-1:0] r_csum, n_csum;
    logic [BYTE_W-1:0] r_psum, n_psum;
    logic [BYTE_W-1:0] r_hdr,  n_hdr;

    logic [BYTE_W-1:0] plain;
    logic [BYTE_W-1:0] chk;
    logic [SIZE_W-1:0] size_full;
    logic              at_end;

    always_comb begin
        // Payload rule rotates on the byte position mod 4
        unique case (r_count[1:0])
            2'd0: plain = i_byte - {i_key[6:0], 1'b0};
            2'd1: plain = i_byte + {3'b000, i_key[7:3]};
            2'd2: plain = i_byte - {i_key[5:0], 2'b00};
            2'd3: plain = i_byte + {5'b00000, i_key[7:5]};
            default: plain = i_byte;
        endcase
    end

    assign size_full = {i_byte, r_size[BYTE_W-1:0]};
    assign at_end    = ({1'b0, r_count} + 17'd1) >= {1'b0, r_size};
    assign chk       = (r_csum + i_byte) - (r_psum + plain);

    always_comb begin
        n_count   = r_count;
        n_size    = r_size;
        n_key_pos = r_key_pos;
        n_csum    = r_csum;
        n_psum    = r_psum;
        n_hdr     = r_hdr;

        o_res.out_byte    = i_byte;
        o_res.last        = 1'b0;
        o_res.status      = ST_OK;
        o_res.packet_size = '0;

        unique case (r_count)
            POS_SIZE_LO: begin
                n_size  = {{(SIZE_W-BYTE_W){1'b0}}, i_byte};
                n_csum  = '0;
                n_psum  = '0;
                n_count = POS_SIZE_HI;
            end
            POS_SIZE_HI: begin
                n_size = size_full;
                if (size_full < MIN_SIZE || size_full > i_max_size) begin
                    n_count           = POS_SIZE_LO;
                    o_res.last        = 1'b1;
                    o_res.status      = ST_BAD_SIZE;
                    o_res.packet_size = size_full;
                end else begin
                    n_count = POS_KEY_IDX;
                end
            end
            POS_KEY_IDX: begin
                // i_key was read at the even entry chosen by this byte
                n_key_pos = i_key;
                n_count   = POS_CHECK;
            end
            POS_CHECK: begin
                n_hdr   = i_byte;
                n_count = r_count + 16'd1;
            end
            default: begin
                o_res.out_byte = plain;
                n_key_pos      = r_key_pos + 8'd1;
                n_csum         = r_csum + i_byte;
                n_psum         = r_psum + plain;
                if (at_end) begin
                    n_count    = POS_SIZE_LO;
                    o_res.last = 1'b1;
                    if (chk != r_hdr) begin
                        o_res.status      = ST_CHECKSUM;
                        o_res.packet_size = r_size;
                    end
                end else begin
                    n_count = r_count + 16'd1;
                end
            end
        endcase

        if (!i_step) begin
            n_count   = r_count;
            n_size    = r_size;
            n_key_pos = r_key_pos;
            n_csum    = r_csum;
            n_psum    = r_psum;
            n_hdr     = r_hdr;
        end
    end

    // Read for the next byte is issued on its accept, from the state this step leaves
    assign o_rd_addr = (n_count == POS_KEY_IDX) ? AW'({i_next_byte, 1'b0})
                                                : AW'({n_key_pos, 1'b1});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_size    <= '0;
            r_key_pos <= '0;
            r_csum    <= '0;
            r_psum    <= '0;
            r_hdr     <= '0;
        end else begin
            r_count   <= n_count;
            r_size    <= n_size;
            r_key_pos <= n_key_pos;
            r_csum    <= n_csum;
            r_psum    <= n_psum;
            r_hdr     <= n_hdr;
        end
    end

endmodule

`default_nettype wire
